// ===== hdl/mt19937_random_word_generator_assert.svh =====
// assertion macros for the mt19937 random word generator checker
`ifndef MT19937_RANDOM_WORD_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_WORD_GENERATOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define MTRWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication with the consequent in the next cycle
`define MTRWG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/mtrwg_pkg.sv =====
// shared constants, types and tempering function of the mt19937 generator
package mtrwg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned SHIFT_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned IDX_W        = 10;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  localparam logic [IDX_W-1:0] SEED_IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] SEED_IDX_LAST  = IDX_W'(STATE_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEED = 3'b010,
    ST_DRAW = 3'b100
  } state_e;

  typedef struct packed {
    logic              start;
    logic              step;
    logic [WORD_W-1:0] seed;
  } seed_ctrl_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hdl/mt19937_random_word_generator.sv =====
// mt19937 random word generator: shift line of state cells, seeder and output stage
// a draw is accepted every cycle once seeded while the output is taken; its word appears in the cycle after acceptance
// each draw twists one word on the fly from the taps at cells 0, 1 and 397 of the line
// a reseed writes its seed word at acceptance, then s_axis_tready stays low while the seeder fills the other cells
// a draw before any seed seeds with 5489 first and delivers its word once that seeding is done
// reset clears control state only; the cell words stay undefined until the first seed
module mt19937_random_word_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic        s_axis_tuser,   // [0] action (1 = reseed, 0 = draw)
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] random_word
);

  localparam int unsigned LastCell = mtrwg_pkg::STATE_WORDS - 1;

  // state line: cell 0 holds the word that the next twist replaces
  logic [mtrwg_pkg::WORD_W-1:0] cell_word [mtrwg_pkg::STATE_WORDS];

  mtrwg_pkg::state_e state_q, state_d;
  logic              seeded_q, seeded_d;
  logic              pend_q, pend_d;     // draw waiting for the default seed
  logic              out_valid_q, out_valid_d;
  logic [mtrwg_pkg::WORD_W-1:0] out_data_q;

  logic                         in_fire;
  logic                         out_free;
  logic                         start_seed;
  logic                         draw_step;
  logic                         shift_en;
  logic                         seed_last;
  logic [mtrwg_pkg::WORD_W-1:0] seed_word;
  logic [mtrwg_pkg::WORD_W-1:0] twist_word;
  logic [mtrwg_pkg::WORD_W-1:0] chain_in;
  mtrwg_pkg::seed_ctrl_t        seed_ctrl;

  // handshake: one request at a time while idle, and only with room at the output
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == mtrwg_pkg::ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // a reseed, or a draw that finds the generator never seeded, starts the recurrence
  assign start_seed = in_fire && (s_axis_tuser || !seeded_q);

  // one twist step per draw, either straight away or after the default seed
  assign draw_step = (in_fire && !s_axis_tuser && seeded_q) ||
                     ((state_q == mtrwg_pkg::ST_DRAW) && out_free);

  assign shift_en = start_seed || (state_q == mtrwg_pkg::ST_SEED) || draw_step;
  assign chain_in = draw_step ? twist_word : seed_word;

  assign seed_ctrl.start = start_seed;
  assign seed_ctrl.step  = (state_q == mtrwg_pkg::ST_SEED);
  assign seed_ctrl.seed  = s_axis_tuser ? s_axis_tdata : mtrwg_pkg::DEFAULT_SEED;

  mtrwg_seeder u_seeder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (seed_ctrl),
    .word_o (seed_word),
    .last_o (seed_last)
  );

  mtrwg_twist u_twist (
    .cur_i  (cell_word[0]),
    .next_i (cell_word[1]),
    .far_i  (cell_word[mtrwg_pkg::SHIFT_OFFSET]),
    .word_o (twist_word)
  );

  // row of cells, each shifting toward cell 0; new words enter at the far end
  for (genvar i = 0; i < mtrwg_pkg::STATE_WORDS; i++) begin : g_cell
    if (i == LastCell) begin : g_tail
      mtrwg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (chain_in),
        .word_o  (cell_word[i])
      );
    end else begin : g_body
      mtrwg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (cell_word[i+1]),
        .word_o  (cell_word[i])
      );
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    seeded_d = seeded_q;
    pend_d   = pend_q;
    unique case (state_q)
      mtrwg_pkg::ST_IDLE: begin
        if (start_seed) begin
          state_d  = mtrwg_pkg::ST_SEED;
          seeded_d = 1'b1;
          pend_d   = !s_axis_tuser;
        end
      end
      mtrwg_pkg::ST_SEED: begin
        if (seed_last) begin
          state_d = pend_q ? mtrwg_pkg::ST_DRAW : mtrwg_pkg::ST_IDLE;
        end
      end
      mtrwg_pkg::ST_DRAW: begin
        if (out_free) begin
          state_d = mtrwg_pkg::ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      default: begin
        state_d = mtrwg_pkg::ST_IDLE;
      end
    endcase
  end

  // output register: holds a tempered word until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (draw_step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_step) begin
      out_data_q <= mtrwg_pkg::temper(twist_word);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtrwg_pkg::ST_IDLE;
      seeded_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/mtrwg_cell.sv =====
// one state word of the shift line
module mtrwg_cell (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic [mtrwg_pkg::WORD_W-1:0]  word_i,
  output logic [mtrwg_pkg::WORD_W-1:0]  word_o
);

  logic [mtrwg_pkg::WORD_W-1:0] word_q;

  // payload only, undefined until seeded
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

// ===== hdl/mtrwg_twist.sv =====
// twist of one state word from the current, next and far taps
module mtrwg_twist (
  input  logic [mtrwg_pkg::WORD_W-1:0] cur_i,
  input  logic [mtrwg_pkg::WORD_W-1:0] next_i,
  input  logic [mtrwg_pkg::WORD_W-1:0] far_i,
  output logic [mtrwg_pkg::WORD_W-1:0] word_o
);

  logic [mtrwg_pkg::WORD_W-1:0] y;
  logic [mtrwg_pkg::WORD_W-1:0] mix;

  assign y      = (cur_i & mtrwg_pkg::HIGH_BIT) | (next_i & mtrwg_pkg::LOW_BITS);
  assign mix    = y[0] ? mtrwg_pkg::TWIST_MATRIX : '0;
  assign word_o = far_i ^ (y >> 1) ^ mix;

endmodule

// ===== hdl/mtrwg_seeder.sv =====
// seed recurrence, one state word per cycle
module mtrwg_seeder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mtrwg_pkg::seed_ctrl_t         ctrl_i,
  output logic [mtrwg_pkg::WORD_W-1:0]  word_o,
  output logic                          last_o
);

  logic [mtrwg_pkg::WORD_W-1:0] prev_q, prev_d;
  logic [mtrwg_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [mtrwg_pkg::WORD_W-1:0] mixed;
  logic [mtrwg_pkg::WORD_W-1:0] prod;

  assign mixed = prev_q ^ (prev_q >> 30);
  assign prod  = mixed * mtrwg_pkg::SEED_MULT;

  always_comb begin
    if (ctrl_i.start) begin
      word_o = ctrl_i.seed;
    end else begin
      word_o = prod + {{(mtrwg_pkg::WORD_W - mtrwg_pkg::IDX_W){1'b0}}, idx_q};
    end
  end

  assign last_o = (idx_q == mtrwg_pkg::SEED_IDX_LAST);

  always_comb begin
    prev_d = prev_q;
    idx_d  = idx_q;
    if (ctrl_i.start) begin
      prev_d = word_o;
      idx_d  = mtrwg_pkg::SEED_IDX_FIRST;
    end else if (ctrl_i.step) begin
      prev_d = word_o;
      idx_d  = idx_q + mtrwg_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== hdl/mtrwg_checker.sv =====
// port-level checks of the mt19937 random word generator
`include "mt19937_random_word_generator_assert.svh"

module mtrwg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic in_fire;
  logic seed_fire;
  logic draw_fire;
  logic out_stall;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign seed_fire = in_fire && s_axis_tuser;
  assign draw_fire = in_fire && !s_axis_tuser;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a result stays offered, unchanged, until taken
  `MTRWG_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result not held")

  // a reseed keeps the request side busy while the state is filled
  `MTRWG_ASSERT_NEXT(a_seed_busy, seed_fire, !s_axis_tready, "request taken during seeding")

  // a reseed never produces a result by itself
  `MTRWG_ASSERT_NEXT(a_seed_silent, seed_fire && !m_axis_tvalid, !m_axis_tvalid, "reseed gave a result")

  // a draw either yields a word next cycle or starts the default seed
  `MTRWG_ASSERT_NEXT(a_draw_answer, draw_fire, m_axis_tvalid || !s_axis_tready, "draw not answered")

  // a new result follows a draw request or the end of the default seed
  `MTRWG_ASSERT(a_no_result_unprompted, !$rose(m_axis_tvalid) || $past(draw_fire) || !$past(s_axis_tready), "result with no draw")

endmodule

bind mt19937_random_word_generator mtrwg_checker u_mtrwg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
